// File: hw/rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, codes and the step-sequencing function for the sensorless
// six-step commutator.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Field widths
  localparam int unsigned DutyW     = 16;
  localparam int unsigned TickW     = 16;
  localparam int unsigned IntervalW = 9;
  localparam int unsigned StepW     = 3;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [StepW-1:0] NumSteps = 3'd6;

  // floor(x/15) for x < 512 is (x * 2185) >> 15
  localparam int unsigned RecipW     = 12;
  localparam int unsigned RecipShift = 15;
  localparam logic [RecipW-1:0] Recip15 = 12'd2185;

  // Reset values of the configuration registers
  localparam logic [DutyW-1:0]     MotorDutyRst     = 16'd0;
  localparam logic [DutyW-1:0]     StartupDutyRst   = 16'd500;
  localparam logic [TickW-1:0]     AlignTicksRst    = 16'd1500;
  localparam logic [IntervalW-1:0] FirstIntervalRst = 9'd300;
  localparam logic [IntervalW-1:0] EndIntervalRst   = 9'd25;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_START  = 2'd2,
    OP_STOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ALIGN  = 2'd1,
    MODE_RAMP   = 2'd2,
    MODE_CLOSED = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOTOR_DUTY     = 3'd0,
    CFG_STARTUP_DUTY   = 3'd1,
    CFG_ALIGN_TICKS    = 3'd2,
    CFG_FIRST_INTERVAL = 3'd3,
    CFG_END_INTERVAL   = 3'd4
  } cfg_idx_e;

  localparam logic [PhaseW-1:0] PH_NONE = 2'd0;
  localparam logic [PhaseW-1:0] PH_A    = 2'd1;
  localparam logic [PhaseW-1:0] PH_B    = 2'd2;
  localparam logic [PhaseW-1:0] PH_C    = 2'd3;

  // Bridge pattern and sensing for one step
  typedef struct packed {
    logic [PhaseW-1:0] high_side;
    logic [PhaseW-1:0] low_side;
    logic [DutyW-1:0]  duty;
    logic [PhaseW-1:0] sense_phase;
    logic              sense_rising;
  } drive_t;

  // Step after the given one, wrapping 6 -> 1; shut-down goes to 1
  function automatic logic [StepW-1:0] next_step(input logic [StepW-1:0] s);
    logic [StepW-1:0] r;
    if (s >= NumSteps || s == '0) begin
      r = 3'd1;
    end else begin
      r = s + 3'd1;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ssc_drive_decode.sv
// ----------------------------------------------------------------------------
// ssc_drive_decode
// Turns step and mode into the bridge pattern, duty and sense selection.
// ----------------------------------------------------------------------------
module ssc_drive_decode (
  input  logic [ssc_pkg::StepW-1:0] step_i,
  input  ssc_pkg::mode_e            mode_i,
  input  logic [ssc_pkg::DutyW-1:0] motor_duty_i,
  input  logic [ssc_pkg::DutyW-1:0] startup_duty_i,
  output ssc_pkg::drive_t           drive_o
);

  logic [ssc_pkg::StepW-1:0] s;

  // out-of-range step or idle drives nothing
  assign s = (step_i > ssc_pkg::NumSteps || mode_i == ssc_pkg::MODE_IDLE) ? '0 : step_i;

  always_comb begin
    drive_o = '0;
    unique case (s)
      3'd1: begin
        drive_o.high_side   = ssc_pkg::PH_A;
        drive_o.low_side    = ssc_pkg::PH_B;
        drive_o.sense_phase = ssc_pkg::PH_C;
        drive_o.sense_rising = 1'b1;
      end
      3'd2: begin
        drive_o.high_side   = ssc_pkg::PH_A;
        drive_o.low_side    = ssc_pkg::PH_C;
        drive_o.sense_phase = ssc_pkg::PH_B;
        drive_o.sense_rising = 1'b0;
      end
      3'd3: begin
        drive_o.high_side   = ssc_pkg::PH_B;
        drive_o.low_side    = ssc_pkg::PH_C;
        drive_o.sense_phase = ssc_pkg::PH_A;
        drive_o.sense_rising = 1'b1;
      end
      3'd4: begin
        drive_o.high_side   = ssc_pkg::PH_B;
        drive_o.low_side    = ssc_pkg::PH_A;
        drive_o.sense_phase = ssc_pkg::PH_C;
        drive_o.sense_rising = 1'b0;
      end
      3'd5: begin
        drive_o.high_side   = ssc_pkg::PH_C;
        drive_o.low_side    = ssc_pkg::PH_A;
        drive_o.sense_phase = ssc_pkg::PH_B;
        drive_o.sense_rising = 1'b1;
      end
      3'd6: begin
        drive_o.high_side   = ssc_pkg::PH_C;
        drive_o.low_side    = ssc_pkg::PH_B;
        drive_o.sense_phase = ssc_pkg::PH_A;
        drive_o.sense_rising = 1'b0;
      end
      default: begin
        drive_o.high_side   = ssc_pkg::PH_NONE;
        drive_o.low_side    = ssc_pkg::PH_NONE;
        drive_o.sense_phase = ssc_pkg::PH_NONE;
        drive_o.sense_rising = 1'b0;
      end
    endcase

    if (s == '0) begin
      drive_o.duty = '0;
    end else if (mode_i == ssc_pkg::MODE_CLOSED) begin
      drive_o.duty = motor_duty_i;
    end else begin
      drive_o.duty = startup_duty_i;
    end
  end

endmodule

// File: hw/rtl/sensorless_six_step_commutator.sv
// ----------------------------------------------------------------------------
// sensorless_six_step_commutator
// Six-step sensorless commutator: align, open-loop ramp, then back-EMF
// driven commutation, with one result transfer per input transfer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  input   | in        | in_valid_i / in_ready_o | op_i, comparator_i
//  result  | out       | out_valid_o/out_ready_i | high_side_o, low_side_o,
//          |           |                         | pwm_duty_o, sense_phase_o,
//          |           |                         | sense_rising_o, step_o, mode_o
//  config  | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One input transfer per cycle while in_ready_o is high; its result sits in
//  the result register from the cycle after. Throughput is set by the single
//  result register: in_ready_o is high while that register is empty or being
//  drained in the same cycle. Reset clears step, mode, tick count and interval
//  and loads the configuration defaults. A stalled result holds and blocks new
//  input only until it is taken. cfg_ready_o is always high.
//
module sensorless_six_step_commutator (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     op_i,
  input  logic                           comparator_i,

  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ssc_pkg::PhaseW-1:0]     high_side_o,
  output logic [ssc_pkg::PhaseW-1:0]     low_side_o,
  output logic [ssc_pkg::DutyW-1:0]      pwm_duty_o,
  output logic [ssc_pkg::PhaseW-1:0]     sense_phase_o,
  output logic                           sense_rising_o,
  output logic [ssc_pkg::StepW-1:0]      step_o,
  output logic [1:0]                     mode_o,

  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ssc_pkg::CfgDataW-1:0]   cfg_data_i
);

  // Configuration registers
  logic [ssc_pkg::DutyW-1:0]     motor_duty_q, startup_duty_q;
  logic [ssc_pkg::TickW-1:0]     align_ticks_q;
  logic [ssc_pkg::IntervalW-1:0] first_interval_q, end_interval_q;

  // Commutation state
  logic [ssc_pkg::StepW-1:0]     step_q, step_d;
  ssc_pkg::mode_e                mode_q, mode_d;
  logic [ssc_pkg::TickW-1:0]     tick_q, tick_d;
  logic [ssc_pkg::IntervalW-1:0] interval_q, interval_d;

  // Result register
  logic                          out_valid_q, out_valid_d;
  ssc_pkg::drive_t               drive_q, drive_d;
  logic [ssc_pkg::StepW-1:0]     res_step_q;
  ssc_pkg::mode_e                res_mode_q;

  logic in_xfer;
  logic [ssc_pkg::TickW-1:0] tick_inc;

  // Interval shrink: interval - (interval/15 + 1), floored at zero.
  // The divide is a multiply by a reciprocal, exact for 9-bit intervals.
  localparam int unsigned ProdW = ssc_pkg::IntervalW + ssc_pkg::RecipW;
  logic [ProdW-1:0]              prod;
  logic [ssc_pkg::IntervalW-1:0] quot, dec, shrunk;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign tick_inc = tick_q + 16'd1;
  assign prod     = ProdW'(interval_q) * ProdW'(ssc_pkg::Recip15);
  assign quot     = ssc_pkg::IntervalW'(prod >> ssc_pkg::RecipShift);
  assign dec      = quot + 9'd1;
  assign shrunk   = (interval_q > dec) ? (interval_q - dec) : '0;

  // Next state for the item being transferred in
  always_comb begin
    step_d     = step_q;
    mode_d     = mode_q;
    tick_d     = tick_q;
    interval_d = interval_q;
    if (in_xfer) begin
      unique case (ssc_pkg::op_e'(op_i))
        ssc_pkg::OP_START: begin
          // also restarts alignment when already running
          step_d     = 3'd1;
          mode_d     = ssc_pkg::MODE_ALIGN;
          tick_d     = '0;
          interval_d = first_interval_q;
        end
        ssc_pkg::OP_STOP: begin
          step_d     = '0;
          mode_d     = ssc_pkg::MODE_IDLE;
          tick_d     = '0;
          interval_d = '0;
        end
        ssc_pkg::OP_TICK: begin
          if (mode_q == ssc_pkg::MODE_ALIGN) begin
            tick_d = tick_inc;
            if (tick_inc >= align_ticks_q) begin
              mode_d = ssc_pkg::MODE_RAMP;
              tick_d = '0;
            end
          end else if (mode_q == ssc_pkg::MODE_RAMP) begin
            tick_d = tick_inc;
            if (tick_inc >= ssc_pkg::TickW'(interval_q)) begin
              tick_d     = '0;
              interval_d = shrunk;
              // ramp end keeps the step that is on
              if (shrunk < end_interval_q) begin
                mode_d = ssc_pkg::MODE_CLOSED;
              end else begin
                step_d = ssc_pkg::next_step(step_q);
              end
            end
          end
        end
        ssc_pkg::OP_SAMPLE: begin
          // odd steps wait for a high comparator, even steps for a low one
          if (mode_q == ssc_pkg::MODE_CLOSED && step_q >= 3'd1 &&
              step_q <= ssc_pkg::NumSteps && (step_q[0] == comparator_i)) begin
            step_d = ssc_pkg::next_step(step_q);
          end
        end
        default: begin
          step_d = step_q;
        end
      endcase
    end
  end

  ssc_drive_decode u_decode (
    .step_i         (step_d),
    .mode_i         (mode_d),
    .motor_duty_i   (motor_duty_q),
    .startup_duty_i (startup_duty_q),
    .drive_o        (drive_d)
  );

  assign out_valid_d = in_xfer || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_duty_q     <= ssc_pkg::MotorDutyRst;
      startup_duty_q   <= ssc_pkg::StartupDutyRst;
      align_ticks_q    <= ssc_pkg::AlignTicksRst;
      first_interval_q <= ssc_pkg::FirstIntervalRst;
      end_interval_q   <= ssc_pkg::EndIntervalRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ssc_pkg::CFG_MOTOR_DUTY:     motor_duty_q     <= cfg_data_i;
        ssc_pkg::CFG_STARTUP_DUTY:   startup_duty_q   <= cfg_data_i;
        ssc_pkg::CFG_ALIGN_TICKS:    align_ticks_q    <= cfg_data_i;
        ssc_pkg::CFG_FIRST_INTERVAL: first_interval_q <= cfg_data_i[ssc_pkg::IntervalW-1:0];
        ssc_pkg::CFG_END_INTERVAL:   end_interval_q   <= cfg_data_i[ssc_pkg::IntervalW-1:0];
        default: begin
          // unmapped index, write dropped
          motor_duty_q <= motor_duty_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      mode_q      <= ssc_pkg::MODE_IDLE;
      tick_q      <= '0;
      interval_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      mode_q      <= mode_d;
      tick_q      <= tick_d;
      interval_q  <= interval_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      drive_q    <= drive_d;
      res_step_q <= step_d;
      res_mode_q <= mode_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign high_side_o    = drive_q.high_side;
  assign low_side_o     = drive_q.low_side;
  assign pwm_duty_o     = drive_q.duty;
  assign sense_phase_o  = drive_q.sense_phase;
  assign sense_rising_o = drive_q.sense_rising;
  assign step_o         = res_step_q;
  assign mode_o         = res_mode_q;

`ifndef SYNTHESIS
  // Shut down exactly when idle
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ssc_pkg::MODE_IDLE) == (step_q == '0))
    else $error("step and mode disagree on shut-down");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= ssc_pkg::NumSteps)
    else $error("commutation step out of range");

  a_stop_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op_i == ssc_pkg::OP_STOP) |=> (mode_q == ssc_pkg::MODE_IDLE && tick_q == '0))
    else $error("stop did not shut down");

  a_xfer_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (out_valid_o && step_o == step_q && mode_o == mode_q))
    else $error("result does not match state after transfer");
`endif

endmodule

// File: tb/sv/tb_sensorless_six_step_commutator.sv
// ----------------------------------------------------------------------------
// tb_sensorless_six_step_commutator
// Self-checking bench for the six-step commutator. A clocked driver sends
// queued commands (tick, sample, start, stop) with random gaps, and a clocked
// monitor takes results under random back-pressure. Each result is checked
// against a bit-exact model of the align / ramp / closed-loop sequencer kept
// in step with the input transfers. A short directed part comes first, then
// mostly well-formed start-align-ramp-run sequences under several register
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_sensorless_six_step_commutator;
  timeunit 1ns;
  timeprecision 1ps;

  import ssc_pkg::*;

  // Generous bound: every transfer at its longest gap and stall, several times
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned SideIn     = 0;
  localparam int unsigned SideOut    = 1;

  // One command waiting for the driver; hold_off makes the driver wait until
  // every outstanding result has been taken before presenting it
  typedef struct packed {
    op_e  op;
    logic cmp;
    logic hold_off;
  } motor_cmd_t;

  // Everything the block reports for one command
  typedef struct packed {
    logic [PhaseW-1:0] high_side;
    logic [PhaseW-1:0] low_side;
    logic [DutyW-1:0]  duty;
    logic [PhaseW-1:0] sense_phase;
    logic              sense_rising;
    logic [StepW-1:0]  step;
    logic [1:0]        mode;
  } bridge_state_t;

  logic                clk_i;
  logic                rst_ni    = 1'b0;

  logic                in_valid  = 1'b0;
  logic                in_ready;
  op_e                 in_op     = OP_TICK;
  logic                in_cmp    = 1'b0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PhaseW-1:0]   high_side, low_side, sense_phase;
  logic [DutyW-1:0]    pwm_duty;
  logic                sense_rising;
  logic [StepW-1:0]    step;
  logic [1:0]          mode;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_e            cfg_index = CFG_MOTOR_DUTY;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // Model state: registers, then sequencer
  logic [DutyW-1:0]     motor_duty_q   = MotorDutyRst;
  logic [DutyW-1:0]     startup_duty_q = StartupDutyRst;
  logic [TickW-1:0]     align_ticks_q  = AlignTicksRst;
  logic [IntervalW-1:0] first_iv_q     = FirstIntervalRst;
  logic [IntervalW-1:0] end_iv_q       = EndIntervalRst;

  logic [StepW-1:0]     step_q     = '0;
  mode_e                mode_q     = MODE_IDLE;
  logic [TickW-1:0]     ticks_q    = '0;
  logic [IntervalW-1:0] interval_q = '0;

  motor_cmd_t    pending_cmds[$];
  bridge_state_t due_bridge_q[$];

  int unsigned   faults;
  int unsigned   queued;
  int unsigned   quiet_left[2];
  int unsigned   in_gap, out_stall, cycles;
  logic          in_taken;
  motor_cmd_t    next_cmd;
  bridge_state_t got, want;

  sensorless_six_step_commutator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (in_op),
    .comparator_i   (in_cmp),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .high_side_o    (high_side),
    .low_side_o     (low_side),
    .pwm_duty_o     (pwm_duty),
    .sense_phase_o  (sense_phase),
    .sense_rising_o (sense_rising),
    .step_o         (step),
    .mode_o         (mode),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // 6 wraps to 1; shut-down also restarts at 1
  function automatic logic [StepW-1:0] step_after(input logic [StepW-1:0] s);
    return (s == '0 || s >= NumSteps) ? 3'd1 : s + 3'd1;
  endfunction

  // Apply one accepted command to the model and queue the bridge state it gives
  task automatic commutate(input op_e op, input logic cmp);
    logic [IntervalW-1:0] shrink;
    logic [StepW-1:0]     s;
    bridge_state_t        r;
    case (op)
      OP_START: begin
        // also a restart when already running
        step_q     = 3'd1;
        mode_q     = MODE_ALIGN;
        ticks_q    = '0;
        interval_q = first_iv_q;
      end
      OP_STOP: begin
        step_q     = '0;
        mode_q     = MODE_IDLE;
        ticks_q    = '0;
        interval_q = '0;
      end
      OP_TICK: begin
        // ticks only matter while aligning or ramping
        if (mode_q == MODE_ALIGN) begin
          ticks_q = ticks_q + 16'd1;
          if (ticks_q >= align_ticks_q) begin
            mode_q  = MODE_RAMP;
            ticks_q = '0;
          end
        end else if (mode_q == MODE_RAMP) begin
          ticks_q = ticks_q + 16'd1;
          if (ticks_q >= {7'd0, interval_q}) begin
            // shrink by interval/15 + 1, saturating at zero
            shrink     = interval_q / 9'd15 + 9'd1;
            ticks_q    = '0;
            interval_q = (interval_q > shrink) ? interval_q - shrink : '0;
            // the step on the bridge when the ramp ends is kept
            if (interval_q < end_iv_q) begin
              mode_q = MODE_CLOSED;
            end else begin
              step_q = step_after(step_q);
            end
          end
        end
      end
      default: begin
        // back-EMF sample: odd steps move on a 1, even steps on a 0
        if (mode_q == MODE_CLOSED && step_q >= 3'd1 && step_q <= NumSteps &&
            step_q[0] == cmp) begin
          step_q = step_after(step_q);
        end
      end
    endcase

    s = (mode_q == MODE_IDLE || step_q > NumSteps) ? '0 : step_q;
    r.step = step_q;
    r.mode = mode_q;
    case (mode_q)
      MODE_CLOSED:           r.duty = motor_duty_q;
      MODE_ALIGN, MODE_RAMP: r.duty = startup_duty_q;
      default:               r.duty = '0;
    endcase
    if (s == '0) begin
      r.duty = '0;
    end
    case (s)
      3'd1:    {r.high_side, r.low_side, r.sense_phase, r.sense_rising} =
               {PH_A, PH_B, PH_C, 1'b1};
      3'd2:    {r.high_side, r.low_side, r.sense_phase, r.sense_rising} =
               {PH_A, PH_C, PH_B, 1'b0};
      3'd3:    {r.high_side, r.low_side, r.sense_phase, r.sense_rising} =
               {PH_B, PH_C, PH_A, 1'b1};
      3'd4:    {r.high_side, r.low_side, r.sense_phase, r.sense_rising} =
               {PH_B, PH_A, PH_C, 1'b0};
      3'd5:    {r.high_side, r.low_side, r.sense_phase, r.sense_rising} =
               {PH_C, PH_A, PH_B, 1'b1};
      3'd6:    {r.high_side, r.low_side, r.sense_phase, r.sense_rising} =
               {PH_C, PH_B, PH_A, 1'b0};
      default: {r.high_side, r.low_side, r.sense_phase, r.sense_rising} =
               {PH_NONE, PH_NONE, PH_NONE, 1'b0};
    endcase
    due_bridge_q.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Clock, gaps, driver and monitor
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, now and then a quiet stretch with none
  function automatic int unsigned draw_gap(input int unsigned side);
    int unsigned r;
    if (quiet_left[side] != 0) begin
      quiet_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet_left[side] = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // Driver: the model follows each input transfer at the edge it happens
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap   = 0;
    end else begin
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        commutate(in_op, in_cmp);
      end
      // valid and payload are only touched once the current item has gone
      if (!in_valid || in_taken) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].hold_off && due_bridge_q.size() != 0)) begin
          next_cmd = pending_cmds.pop_front();
          in_op    <= next_cmd.op;
          in_cmp   <= next_cmd.cmp;
          in_valid <= 1'b1;
          in_gap   = draw_gap(SideIn);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_fault(input string what, input bridge_state_t exp_s,
                              input bridge_state_t act_s);
    faults++;
    if (faults <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected hs=%0d ls=%0d duty=%0d sp=%0d rise=%0d step=%0d mode=%0d",
               exp_s.high_side, exp_s.low_side, exp_s.duty, exp_s.sense_phase,
               exp_s.sense_rising, exp_s.step, exp_s.mode);
      $display("  actual   hs=%0d ls=%0d duty=%0d sp=%0d rise=%0d step=%0d mode=%0d",
               act_s.high_side, act_s.low_side, act_s.duty, act_s.sense_phase,
               act_s.sense_rising, act_s.step, act_s.mode);
    end
  endtask

  // Monitor: check each result transfer, then pick the next ready level
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.high_side    = high_side;
        got.low_side     = low_side;
        got.duty         = pwm_duty;
        got.sense_phase  = sense_phase;
        got.sense_rising = sense_rising;
        got.step         = step;
        got.mode         = mode;
        if (due_bridge_q.size() == 0) begin
          report_fault("result transfer with nothing outstanding", '0, got);
        end else begin
          want = due_bridge_q.pop_front();
          if (got.high_side !== want.high_side || got.low_side !== want.low_side ||
              got.duty !== want.duty || got.sense_phase !== want.sense_phase ||
              got.sense_rising !== want.sense_rising || got.step !== want.step ||
              got.mode !== want.mode) begin
            report_fault("result mismatch", want, got);
          end
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_stall = draw_gap(SideOut);
        out_ready <= (out_stall == 0);
        if (out_stall != 0) begin
          out_stall--;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic queue_cmd(input op_e op, input logic cmp, input logic hold_off);
    motor_cmd_t c;
    c.op       = op;
    c.cmp      = cmp;
    c.hold_off = hold_off;
    pending_cmds.push_back(c);
    queued++;
  endtask

  // Register write; the model takes the value at the transfer edge
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MOTOR_DUTY:     motor_duty_q   = value;
      CFG_STARTUP_DUTY:   startup_duty_q = value;
      CFG_ALIGN_TICKS:    align_ticks_q  = value;
      CFG_FIRST_INTERVAL: first_iv_q     = value[IntervalW-1:0];
      CFG_END_INTERVAL:   end_iv_q       = value[IntervalW-1:0];
      default: ;
    endcase
  endtask

  // Interval registers get random junk above bit 8
  task automatic load_settings(input logic [15:0] motor, input logic [15:0] startup,
                               input logic [15:0] align, input logic [8:0] first_iv,
                               input logic [8:0] last_iv);
    write_reg(CFG_MOTOR_DUTY, motor);
    write_reg(CFG_STARTUP_DUTY, startup);
    write_reg(CFG_ALIGN_TICKS, align);
    write_reg(CFG_FIRST_INTERVAL, {7'($urandom), first_iv});
    write_reg(CFG_END_INTERVAL, {7'($urandom), last_iv});
  endtask

  // Block idle: nothing queued, nothing on the wire, nothing outstanding.
  // Checked between edges so that the driver's updates have all landed.
  task automatic settle();
    while (pending_cmds.size() != 0 || in_valid || due_bridge_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  // One start-align-ramp-run sequence with some noise and the odd broken run
  task automatic add_run();
    int unsigned n_ticks, iv, shrink, n_samples;
    logic        closes;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        queue_cmd(op_e'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)), 1'b0);
      end
    end
    queue_cmd(OP_START, 1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);

    // ticks needed to reach closed loop under the current settings
    n_ticks = (align_ticks_q == 0) ? 1 : align_ticks_q;
    iv      = first_iv_q;
    closes  = 1'b0;
    for (int k = 0; k < 64 && n_ticks < 400; k++) begin
      n_ticks += (iv == 0) ? 1 : iv;
      shrink  = iv / 15 + 1;
      iv      = (iv > shrink) ? iv - shrink : 0;
      if (iv < end_iv_q) begin
        closes = 1'b1;
        break;
      end
    end
    if (!closes || n_ticks > 300) begin
      closes  = 1'b0;
      n_ticks = $urandom_range(5, 40);
    end

    repeat (n_ticks) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_cmd(OP_SAMPLE, 1'($urandom_range(0, 1)), 1'b0);
      end
      if ($urandom_range(0, 199) == 0) begin
        queue_cmd(OP_STOP, 1'($urandom_range(0, 1)), 1'b0);
        return;
      end
      queue_cmd(OP_TICK, 1'($urandom_range(0, 1)), 1'b0);
    end

    if (closes) begin
      n_samples = $urandom_range(4, 40);
      repeat (n_samples) begin
        if ($urandom_range(0, 99) < 8) begin
          queue_cmd(OP_TICK, 1'($urandom_range(0, 1)), 1'b0);
        end else if ($urandom_range(0, 99) < 3) begin
          queue_cmd(OP_START, 1'($urandom_range(0, 1)), 1'b0);
          return;
        end else begin
          queue_cmd(OP_SAMPLE, 1'($urandom_range(0, 1)), 1'b0);
        end
      end
    end
    // otherwise left running, so the next start is a restart
    if ($urandom_range(0, 9) < 6) begin
      queue_cmd(OP_STOP, 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sensorless_six_step_commutator test failed");
    $finish;
  end

  initial begin
    logic [8:0] fi;
    faults = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed, reset settings: items when shut down, start, restart, stop.
    // The restart waits until every earlier result has been taken.
    queue_cmd(OP_TICK, 1'b0, 1'b0);
    queue_cmd(OP_SAMPLE, 1'b1, 1'b0);
    queue_cmd(OP_STOP, 1'b0, 1'b0);
    queue_cmd(OP_START, 1'b0, 1'b0);
    queue_cmd(OP_TICK, 1'b1, 1'b0);
    queue_cmd(OP_SAMPLE, 1'b1, 1'b0);
    queue_cmd(OP_START, 1'b1, 1'b1);
    queue_cmd(OP_STOP, 1'b1, 1'b0);
    settle();

    // Zero align length, interval of 1 that saturates at zero, never closes
    load_settings(16'hFFFF, 16'h0000, 16'd0, 9'd1, 9'd0);
    queue_cmd(OP_START, 1'b0, 1'b0);
    repeat (4) queue_cmd(OP_TICK, 1'b0, 1'b0);
    queue_cmd(OP_SAMPLE, 1'b0, 1'b0);
    queue_cmd(OP_STOP, 1'b0, 1'b0);
    settle();

    // Ramp ends at once (top end value); closed loop walks all six steps
    load_settings(16'd1234, 16'hFFFF, 16'd1, 9'd2, 9'd511);
    queue_cmd(OP_START, 1'b0, 1'b0);
    repeat (4) queue_cmd(OP_TICK, 1'b1, 1'b0);
    queue_cmd(OP_SAMPLE, 1'b0, 1'b0);
    queue_cmd(OP_SAMPLE, 1'b1, 1'b0);
    queue_cmd(OP_SAMPLE, 1'b1, 1'b0);
    repeat (3) begin
      queue_cmd(OP_SAMPLE, 1'b0, 1'b0);
      queue_cmd(OP_SAMPLE, 1'b1, 1'b0);
    end
    queue_cmd(OP_SAMPLE, 1'b0, 1'b0);
    settle();

    // Random phases, each under its own settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_settings(16'h0000, 16'hFFFF, 16'd2, 9'd6, 9'd2);
        // top align length and intervals: long align; a ramp would close after its first interval
        2: load_settings(16'hFFFF, 16'h0000, 16'hFFFF, 9'd511, 9'd511);
        // end value zero: interval bottoms out and every tick steps
        3: load_settings(16'($urandom), 16'($urandom), 16'($urandom_range(0, 3)),
                         9'($urandom_range(1, 20)), 9'd0);
        default: begin
          fi = 9'($urandom_range(1, 24));
          load_settings(16'($urandom), 16'($urandom), 16'($urandom_range(0, 8)),
                        fi, 9'($urandom_range(fi / 2, fi)));
        end
      endcase
      queued = 0;
      while (queued < ((ph == 2) ? 100 : 220)) begin
        add_run();
      end
      settle();
    end

    if (faults == 0 && due_bridge_q.size() == 0) begin
      $display("sensorless_six_step_commutator test passed");
    end else begin
      $display("sensorless_six_step_commutator test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_drive_decode.sv
hw/rtl/sensorless_six_step_commutator.sv
tb/sv/tb_sensorless_six_step_commutator.sv
